// File: rtl/kf1d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kf1d_pkg
// Shared types and constants for the scalar Kalman filter.
// ----------------------------------------------------------------------------
package kf1d_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_STEPS = DATA_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAS_VAR  = 2'd0,
    CFG_MOTION_VAR = 2'd1,
    CFG_INIT_MEAN = 2'd2,
    CFG_INIT_VAR  = 2'd3
  } kf1d_cfg_idx_t;

  // whole number to fixed point, saturated to the unsigned range
  function automatic logic [DATA_W-1:0] fixed_from_int(input logic [DATA_W-1:0] whole);
    logic [2*DATA_W-1:0] wide;
    wide = {{DATA_W{1'b0}}, whole} << FRAC_BITS;
    if (wide[2*DATA_W-1:DATA_W] != '0) begin
      return '1;
    end
    return wide[DATA_W-1:0];
  endfunction

  localparam logic [DATA_W-1:0] MEAS_VAR_RST   = fixed_from_int(32'd4);
  localparam logic [DATA_W-1:0] MOTION_VAR_RST = fixed_from_int(32'd2);
  localparam logic [DATA_W-1:0] INIT_VAR_RST   = fixed_from_int(32'd1000);

  typedef enum logic [1:0] {
    MUL_A = 2'd0,   // |m| * r
    MUL_B = 2'd1,   // |z| * v
    MUL_P = 2'd2    // v * r
  } kf1d_mul_sel_t;

  typedef struct packed {
    logic          load;
    logic          mul_en;
    kf1d_mul_sel_t mul_sel;
    logic          sum_en;
    logic          div_start;
    logic          fin;
  } kf1d_cmd_t;

  typedef struct packed {
    logic div_done;
  } kf1d_sts_t;

endpackage
`default_nettype wire

// File: rtl/kalman_filter_1d.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kalman_filter_1d
// Scalar Kalman filter, Q16.16 fixed point.
//
// Input word (in_valid/in_stall): measurement, motion and a restart bit that
// reloads the initial mean and variance before the step. Result word
// (out_valid/out_stall): updated and predicted mean and variance.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; the user
// must do so only while idle, as the block does not enforce it. One word is
// in flight at a time; the step time is set by the two 32-step restoring
// dividers that run side by side after three passes of the shared multiplier.
// The result sits in an output register; the next word is taken while it
// waits. If the receiver stalls past the next step, the sequencer holds its
// finished result until the register frees. Reset (synchronous) clears the
// estimate to mean 0 and variance 1000.0 and restores the register defaults.
// ----------------------------------------------------------------------------
module kalman_filter_1d (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [kf1d_pkg::DATA_W-1:0] in_measurement,
  input  wire logic signed [kf1d_pkg::DATA_W-1:0] in_motion,
  input  wire logic                               in_restart,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [kf1d_pkg::DATA_W-1:0]      out_updated_mean,
  output logic [kf1d_pkg::DATA_W-1:0]             out_updated_var,
  output logic signed [kf1d_pkg::DATA_W-1:0]      out_predicted_mean,
  output logic [kf1d_pkg::DATA_W-1:0]             out_predicted_var,
  input  wire logic                               cfg_wr_en,
  input  wire logic [kf1d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [kf1d_pkg::DATA_W-1:0]        cfg_wdata
);
  import kf1d_pkg::*;

  kf1d_cmd_t cmd;
  kf1d_sts_t sts;

  kf1d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  kf1d_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_measurement     (in_measurement),
    .in_motion          (in_motion),
    .in_restart         (in_restart),
    .out_updated_mean   (out_updated_mean),
    .out_updated_var    (out_updated_var),
    .out_predicted_mean (out_predicted_mean),
    .out_predicted_var  (out_predicted_var)
  );

endmodule
`default_nettype wire

// File: rtl/kf1d_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kf1d_div
// Restoring divider, one quotient bit per cycle, 32-bit quotient of a
// 64-bit dividend by a 33-bit divisor (quotient must fit in 32 bits).
// ----------------------------------------------------------------------------
module kf1d_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [2*kf1d_pkg::DATA_W-1:0] dividend,
  input  wire logic [kf1d_pkg::DATA_W:0]     divisor,
  output logic                               done,
  output logic [kf1d_pkg::DATA_W-1:0]        quotient
);
  import kf1d_pkg::*;

  logic [DATA_W:0]    rem_r;
  logic [DATA_W-1:0]  lo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DATA_W+1:0]  trial;
  logic [DATA_W+1:0]  diff;
  logic               ge;

  assign trial = {rem_r, lo_r[DATA_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend[2*DATA_W-1:DATA_W]};
      lo_r  <= dividend[DATA_W-1:0];
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[DATA_W:0] : trial[DATA_W:0];
      lo_r  <= {lo_r[DATA_W-2:0], ge};
    end
  end

  assign done     = (cnt_r == '0);
  assign quotient = lo_r;

endmodule
`default_nettype wire

// File: rtl/kf1d_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kf1d_datapath
// Config registers, estimate state, shared multiplier, two dividers and
// the result register.
// ----------------------------------------------------------------------------
module kf1d_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire kf1d_pkg::kf1d_cmd_t              cmd,
  output kf1d_pkg::kf1d_sts_t                   sts,
  input  wire logic                             cfg_wr_en,
  input  wire logic [kf1d_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kf1d_pkg::DATA_W-1:0]      cfg_wdata,
  input  wire logic signed [kf1d_pkg::DATA_W-1:0] in_measurement,
  input  wire logic signed [kf1d_pkg::DATA_W-1:0] in_motion,
  input  wire logic                             in_restart,
  output logic signed [kf1d_pkg::DATA_W-1:0]    out_updated_mean,
  output logic [kf1d_pkg::DATA_W-1:0]           out_updated_var,
  output logic signed [kf1d_pkg::DATA_W-1:0]    out_predicted_mean,
  output logic [kf1d_pkg::DATA_W-1:0]           out_predicted_var
);
  import kf1d_pkg::*;

  localparam logic signed [DATA_W:0] S_MAX = {2'b00, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W:0] S_MIN = {2'b11, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0]      Q_LIM = DATA_W'(2**(DATA_W-1));

  logic [DATA_W-1:0]        meas_var_r, motion_var_r, init_var_r;
  logic signed [DATA_W-1:0] init_mean_r;
  logic signed [DATA_W-1:0] est_mean_r;
  logic [DATA_W-1:0]        est_var_r;

  logic signed [DATA_W-1:0] m_r, mot_r;
  logic [DATA_W-1:0]        m_mag_r, z_mag_r, v_r;
  logic                     m_neg_r, z_neg_r;
  logic [2*DATA_W-1:0]      a_r, b_r, p_r, mag_r;
  logic                     neg_r;
  logic [DATA_W:0]          d_r;

  logic signed [DATA_W-1:0] m_sel;
  logic [DATA_W-1:0]        v_sel;
  logic [DATA_W-1:0]        op1, op2;
  logic [2*DATA_W-1:0]      prod;
  logic [2*DATA_W-1:0]      mag_nxt;
  logic                     neg_nxt;
  logic [DATA_W-1:0]        q_mean, q_var, q_clip;
  logic                     done_m, done_v;
  logic signed [DATA_W:0]   q_signed, q_sat;
  logic signed [DATA_W-1:0] upd_mean;
  logic [DATA_W-1:0]        upd_var;
  logic signed [DATA_W:0]   pm_sum;
  logic signed [DATA_W-1:0] pred_mean;
  logic [DATA_W:0]          pv_sum;
  logic [DATA_W-1:0]        pred_var;
  logic                     d_zero;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_var_r   <= MEAS_VAR_RST;
      motion_var_r <= MOTION_VAR_RST;
      init_mean_r  <= '0;
      init_var_r   <= INIT_VAR_RST;
    end else if (cfg_wr_en) begin
      case (kf1d_cfg_idx_t'(cfg_index))
        CFG_MEAS_VAR:   meas_var_r   <= cfg_wdata;
        CFG_MOTION_VAR: motion_var_r <= cfg_wdata;
        CFG_INIT_MEAN:  init_mean_r  <= cfg_wdata;
        CFG_INIT_VAR:   init_var_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign m_sel = in_restart ? init_mean_r : est_mean_r;
  assign v_sel = in_restart ? init_var_r  : est_var_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r     <= m_sel;
      m_neg_r <= m_sel[DATA_W-1];
      m_mag_r <= m_sel[DATA_W-1] ? DATA_W'(-m_sel) : m_sel;
      z_neg_r <= in_measurement[DATA_W-1];
      z_mag_r <= in_measurement[DATA_W-1] ? DATA_W'(-in_measurement) : in_measurement;
      v_r     <= v_sel;
      mot_r   <= in_motion;
    end
  end

  // shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      MUL_A: begin
        op1 = m_mag_r;
        op2 = meas_var_r;
      end
      MUL_B: begin
        op1 = z_mag_r;
        op2 = v_r;
      end
      MUL_P: begin
        op1 = v_r;
        op2 = meas_var_r;
      end
      default: begin
        op1 = '0;
        op2 = '0;
      end
    endcase
  end

  assign prod = {{DATA_W{1'b0}}, op1} * {{DATA_W{1'b0}}, op2};

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MUL_A:   a_r <= prod;
        MUL_B:   b_r <= prod;
        MUL_P:   p_r <= prod;
        default: ;
      endcase
    end
  end

  // signed numerator as sign and magnitude
  always_comb begin
    if (m_neg_r == z_neg_r) begin
      mag_nxt = a_r + b_r;
      neg_nxt = m_neg_r;
    end else if (a_r >= b_r) begin
      mag_nxt = a_r - b_r;
      neg_nxt = m_neg_r;
    end else begin
      mag_nxt = b_r - a_r;
      neg_nxt = z_neg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      mag_r <= mag_nxt;
      neg_r <= neg_nxt;
      d_r   <= {1'b0, v_r} + {1'b0, meas_var_r};
    end
  end

  kf1d_div u_div_mean (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mag_r),
    .divisor  (d_r),
    .done     (done_m),
    .quotient (q_mean)
  );

  kf1d_div u_div_var (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (p_r),
    .divisor  (d_r),
    .done     (done_v),
    .quotient (q_var)
  );

  assign sts.div_done = done_m & done_v;

  // update and prediction
  always_comb begin
    d_zero   = (d_r == '0);
    q_clip   = (q_mean > Q_LIM) ? Q_LIM : q_mean;
    q_signed = neg_r ? -$signed({1'b0, q_clip}) : $signed({1'b0, q_clip});
    q_sat    = (q_signed > S_MAX) ? S_MAX : q_signed;
    upd_mean = d_zero ? m_r : q_sat[DATA_W-1:0];
    upd_var  = d_zero ? '0 : q_var;
    pm_sum   = {upd_mean[DATA_W-1], upd_mean} + {mot_r[DATA_W-1], mot_r};
    if (pm_sum > S_MAX) begin
      pred_mean = S_MAX[DATA_W-1:0];
    end else if (pm_sum < S_MIN) begin
      pred_mean = S_MIN[DATA_W-1:0];
    end else begin
      pred_mean = pm_sum[DATA_W-1:0];
    end
    pv_sum   = {1'b0, upd_var} + {1'b0, motion_var_r};
    pred_var = pv_sum[DATA_W] ? '1 : pv_sum[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_mean_r <= '0;
      est_var_r  <= INIT_VAR_RST;
    end else if (cmd.fin) begin
      est_mean_r <= pred_mean;
      est_var_r  <= pred_var;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_updated_mean   <= upd_mean;
      out_updated_var    <= upd_var;
      out_predicted_mean <= pred_mean;
      out_predicted_var  <= pred_var;
    end
  end

endmodule
`default_nettype wire

// File: rtl/kf1d_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kf1d_ctrl
// Sequencer for one filter step and the result word valid flag.
// ----------------------------------------------------------------------------
module kf1d_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output kf1d_pkg::kf1d_cmd_t       cmd,
  input  wire kf1d_pkg::kf1d_sts_t  sts
);
  import kf1d_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MA    = 8'b0000_0010,
    ST_MB    = 8'b0000_0100,
    ST_MP    = 8'b0000_1000,
    ST_SUM   = 8'b0001_0000,
    ST_START = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } kf1d_state_t;

  kf1d_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_A;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MA;
        end
      end
      ST_MA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_A;
        state_nxt   = ST_MB;
      end
      ST_MB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_B;
        state_nxt   = ST_MP;
      end
      ST_MP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
